// ----- rtl/nal_stream_codec_probe_unit_defines.svh -----
// Assertion helpers for the stream codec probe.
`ifndef NAL_STREAM_CODEC_PROBE_UNIT_DEFINES_SVH
`define NAL_STREAM_CODEC_PROBE_UNIT_DEFINES_SVH

// Same-cycle implication, quiet while reset is held.
`define NSCP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nscp check failed");

// Next-cycle implication, quiet while reset is held.
`define NSCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nscp check failed");

// Next-cycle implication that also watches the reset cycles.
`define NSCP_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("nscp check failed");

`endif

// ----- rtl/nscp_pkg.sv -----
`timescale 1ns / 1ps
package nscp_pkg;

    localparam int NUM_CODECS = 3;

    // Codec slots of the per-codec state.
    localparam int CODEC_AVC  = 0;
    localparam int CODEC_HEVC = 1;
    localparam int CODEC_VVC  = 2;

    // Result codes.
    localparam logic [1:0] FMT_NONE = 2'd0;
    localparam logic [1:0] FMT_AVC  = 2'd1;
    localparam logic [1:0] FMT_HEVC = 2'd2;
    localparam logic [1:0] FMT_VVC  = 2'd3;

    // Header rules.
    localparam logic [5:0] HEVC_MAX_TYPE = 6'd40;
    localparam logic [5:0] AVC_MAX_TYPE  = 6'd24;
    localparam logic [5:0] ZERO_TYPE     = 6'd0;

    // Parameter-set unit types, indexed by codec slot.
    localparam logic [5:0] SPS_TYPE [NUM_CODECS] = '{6'd7, 6'd33, 6'd15};
    localparam logic [5:0] PPS_TYPE [NUM_CODECS] = '{6'd8, 6'd34, 6'd16};
    localparam logic [5:0] VPS_TYPE [NUM_CODECS] = '{6'd63, 6'd32, 6'd14};
    localparam logic       HAS_VPS  [NUM_CODECS] = '{1'b0, 1'b1, 1'b1};
    // Slot in the two-entry VPS flag vector (HEVC 0, VVC 1).
    localparam logic       VPS_SLOT [NUM_CODECS] = '{1'b0, 1'b0, 1'b1};

    typedef struct packed {
        logic [NUM_CODECS-1:0] rejected;
        logic [NUM_CODECS-1:0] sps;
        logic [NUM_CODECS-1:0] pps;
        logic [1:0]            vps;
    } t_probe_flags;

endpackage

// ----- rtl/nscp_if.sv -----
`timescale 1ns / 1ps
interface nscp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface nscp_fmt_if;
    logic       valid;
    logic       ready;
    logic [1:0] detected_format;

    modport source (output valid, detected_format, input ready);
    modport sink   (input valid, detected_format, output ready);
endinterface

// ----- rtl/nscp_tracker.sv -----
`timescale 1ns / 1ps
module nscp_tracker #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_last_byte,
    output logic [COUNT_WIDTH-1:0]    o_unit_count [nscp_pkg::NUM_CODECS],
    output logic [COUNT_WIDTH-1:0]    o_zero_count [nscp_pkg::NUM_CODECS],
    output nscp_pkg::t_probe_flags    o_flags
);
    import nscp_pkg::*;

    localparam logic [1:0] PH_SEARCH = 2'd0;
    localparam logic [1:0] PH_FIRST  = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;

    logic [1:0]             r_zero_run, n_zero_run;
    logic [1:0]             r_phase, n_phase;
    logic [7:0]             r_first, n_first;
    logic [COUNT_WIDTH-1:0] r_unit_count [NUM_CODECS];
    logic [COUNT_WIDTH-1:0] n_unit_count [NUM_CODECS];
    logic [COUNT_WIDTH-1:0] r_zero_count [NUM_CODECS];
    logic [COUNT_WIDTH-1:0] n_zero_count [NUM_CODECS];
    t_probe_flags           r_flags, n_flags;

    logic                   judge;
    logic [NUM_CODECS-1:0]  rule_ok;
    logic [5:0]             unit_type [NUM_CODECS];
    logic                   clear;

    // Judge the captured header pair when the second byte arrives.
    assign judge = (r_phase == PH_SECOND);

    always_comb begin
        unit_type[CODEC_AVC]  = {1'b0, r_first[4:0]};
        unit_type[CODEC_HEVC] = r_first[6:1];
        unit_type[CODEC_VVC]  = {1'b0, i_data_byte[7:3]};
        rule_ok[CODEC_AVC]    = (unit_type[CODEC_AVC] != ZERO_TYPE) &&
                                (unit_type[CODEC_AVC] <= AVC_MAX_TYPE);
        rule_ok[CODEC_HEVC]   = (unit_type[CODEC_HEVC] <= HEVC_MAX_TYPE);
        rule_ok[CODEC_VVC]    = !r_first[6];
    end

    always_comb begin
        n_first      = r_first;
        n_phase      = r_phase;
        n_flags      = r_flags;
        n_unit_count = r_unit_count;
        n_zero_count = r_zero_count;

        unique case (r_phase)
            PH_FIRST: begin
                n_first = i_data_byte;
                n_phase = PH_SECOND;
            end
            PH_SECOND: begin
                n_phase = PH_SEARCH;
            end
            default: begin
                if (r_zero_run == 2'd2 && i_data_byte == 8'd1) begin
                    n_phase = PH_FIRST;
                end
            end
        endcase

        if (i_data_byte == 8'd0) begin
            n_zero_run = (r_zero_run == 2'd2) ? 2'd2 : r_zero_run + 2'd1;
        end else begin
            n_zero_run = 2'd0;
        end

        for (int c = 0; c < NUM_CODECS; c++) begin
            if (judge) begin
                if (r_first[7] || !rule_ok[c]) begin
                    n_flags.rejected[c] = 1'b1;
                end else begin
                    n_unit_count[c] = (&r_unit_count[c]) ? r_unit_count[c]
                                    : COUNT_WIDTH'(r_unit_count[c] + 1'b1);
                    if (unit_type[c] == PPS_TYPE[c]) begin
                        if (r_flags.sps[c]) begin
                            n_flags.pps[c] = 1'b1;
                        end
                    end else if (unit_type[c] == SPS_TYPE[c]) begin
                        n_flags.sps[c] = 1'b1;
                    end else if (HAS_VPS[c] && unit_type[c] == VPS_TYPE[c]) begin
                        n_flags.vps[VPS_SLOT[c]] = 1'b1;
                    end else if (unit_type[c] == ZERO_TYPE) begin
                        n_zero_count[c] = (&r_zero_count[c]) ? r_zero_count[c]
                                        : COUNT_WIDTH'(r_zero_count[c] + 1'b1);
                    end
                end
            end
        end
    end

    // Drop all probe state after the final word of a buffer.
    assign clear = !i_rst_n || (i_step && i_last_byte);

    always_ff @(posedge i_clk) begin
        if (clear) begin
            r_zero_run <= 2'd0;
            r_phase    <= PH_SEARCH;
            r_first    <= 8'd0;
            r_flags    <= '0;
            for (int c = 0; c < NUM_CODECS; c++) begin
                r_unit_count[c] <= '0;
                r_zero_count[c] <= '0;
            end
        end else if (i_step) begin
            r_zero_run   <= n_zero_run;
            r_phase      <= n_phase;
            r_first      <= n_first;
            r_flags      <= n_flags;
            r_unit_count <= n_unit_count;
            r_zero_count <= n_zero_count;
        end
    end

    assign o_unit_count = n_unit_count;
    assign o_zero_count = n_zero_count;
    assign o_flags      = n_flags;

endmodule

// ----- rtl/nscp_decide.sv -----
`timescale 1ns / 1ps
module nscp_decide #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic [COUNT_WIDTH-1:0] i_unit_count [nscp_pkg::NUM_CODECS],
    input  logic [COUNT_WIDTH-1:0] i_zero_count [nscp_pkg::NUM_CODECS],
    input  nscp_pkg::t_probe_flags i_flags,
    output logic [1:0]             o_format
);
    import nscp_pkg::*;

    logic                   ok_avc, ok_hevc, ok_vvc;
    logic [COUNT_WIDTH-1:0] na, nh, nv;

    // A codec scores only with its parameter sets present and no rejection.
    assign ok_avc  = i_flags.sps[CODEC_AVC] && i_flags.pps[CODEC_AVC] &&
                     !i_flags.rejected[CODEC_AVC];
    assign ok_hevc = i_flags.sps[CODEC_HEVC] && i_flags.pps[CODEC_HEVC] &&
                     i_flags.vps[0] && !i_flags.rejected[CODEC_HEVC];
    assign ok_vvc  = i_flags.sps[CODEC_VVC] && i_flags.pps[CODEC_VVC] &&
                     i_flags.vps[1] && !i_flags.rejected[CODEC_VVC];

    // A score made only of type-0 units counts as none.
    assign na = (ok_avc && i_unit_count[CODEC_AVC] != i_zero_count[CODEC_AVC])
              ? i_unit_count[CODEC_AVC] : '0;
    assign nh = (ok_hevc && i_unit_count[CODEC_HEVC] != i_zero_count[CODEC_HEVC])
              ? i_unit_count[CODEC_HEVC] : '0;
    assign nv = (ok_vvc && i_unit_count[CODEC_VVC] != i_zero_count[CODEC_VVC])
              ? i_unit_count[CODEC_VVC] : '0;

    always_comb begin
        if (&i_flags.rejected) begin
            o_format = FMT_NONE;
        end else if (na == '0 && nh == '0 && nv == '0) begin
            o_format = FMT_NONE;
        end else if (nh == '0) begin
            o_format = (nv > na) ? FMT_VVC : FMT_AVC;
        end else if (na == '0) begin
            o_format = (nv > nh) ? FMT_VVC : FMT_HEVC;
        end else if (nv == '0) begin
            o_format = (na > nh) ? FMT_AVC : FMT_HEVC;
        end else if (nh > na && nh > nv) begin
            o_format = FMT_HEVC;
        end else if (nv > na && nv > nh) begin
            o_format = FMT_VVC;
        end else begin
            o_format = FMT_AVC;
        end
    end

endmodule

// ----- rtl/nal_stream_codec_probe_unit.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Port    Payload                      Notes
// --------  ---  ------  ---------------------------  ------------------------------
// bytes     in   i_byte  data_byte[7:0], last_byte    one word per buffer byte
// format    out  o_fmt   detected_format[1:0]         one word per buffer, on last
//
// One word per cycle unless a last byte waits on a stalled format word.
// The input register feeds the start-code tracker, whose next state also feeds
// the majority decision straight into the output register.
// Reset is synchronous and active low; it clears the probe state and both valids.
// A stalled format word holds only words marked last; plain bytes keep flowing.
module nal_stream_codec_probe_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    nscp_byte_if.sink          i_byte,
    nscp_fmt_if.source         o_fmt
);
    import nscp_pkg::*;

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Output register.
    logic       r_out_valid;
    logic [1:0] r_out_format;

    logic       out_free;
    logic       in_adv;
    logic       in_take;
    logic [1:0] fmt;

    logic [COUNT_WIDTH-1:0] unit_count [NUM_CODECS];
    logic [COUNT_WIDTH-1:0] zero_count [NUM_CODECS];
    t_probe_flags           flags;

    // The output slot is free when empty or being drained this cycle.
    assign out_free = !r_out_valid || o_fmt.ready;

    // Advance the held word unless it is a last byte with nowhere to go.
    assign in_adv  = r_in_valid && (!r_in_last || out_free);
    assign in_take = i_byte.valid && i_byte.ready;

    assign i_byte.ready = !r_in_valid || in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (in_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_byte.data_byte;
            r_in_last <= i_byte.last_byte;
        end
    end

    nscp_tracker #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tracker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (in_adv),
        .i_data_byte  (r_in_byte),
        .i_last_byte  (r_in_last),
        .o_unit_count (unit_count),
        .o_zero_count (zero_count),
        .o_flags      (flags)
    );

    // Decide on the state as it stands after the last byte is taken in.
    nscp_decide #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decide (
        .i_unit_count (unit_count),
        .i_zero_count (zero_count),
        .i_flags      (flags),
        .o_format     (fmt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_fmt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && r_in_last) begin
            r_out_format <= fmt;
        end
    end

    assign o_fmt.valid           = r_out_valid;
    assign o_fmt.detected_format = r_out_format;

endmodule

// ----- rtl/nscp_checker.sv -----
`timescale 1ns / 1ps
`include "nal_stream_codec_probe_unit_defines.svh"
module nscp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_last,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_format
);
    logic [1:0] r_pend;
    logic       last_in;
    logic       word_out;

    assign last_in  = i_in_valid && i_in_ready && i_in_last;
    assign word_out = i_out_valid && i_out_ready;

    // Count buffers closed but not yet reported.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else if (last_in && !word_out) begin
            r_pend <= r_pend + 2'd1;
        end else if (word_out && !last_in) begin
            r_pend <= r_pend - 2'd1;
        end
    end

    `NSCP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_format))
    `NSCP_ASSERT_NOW(a_no_spurious_format, i_clk, i_rst_n, i_out_valid, r_pend != 2'd0)
    `NSCP_ASSERT_NOW(a_two_buffers_max, i_clk, i_rst_n, 1'b1, r_pend != 2'd3)
    `NSCP_ASSERT_NOW(a_flow_when_drained, i_clk, i_rst_n, i_out_ready, i_in_ready)
    `NSCP_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind nal_stream_codec_probe_unit nscp_checker u_nscp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_byte.valid),
    .i_in_ready   (i_byte.ready),
    .i_in_last    (i_byte.last_byte),
    .i_out_valid  (o_fmt.valid),
    .i_out_ready  (o_fmt.ready),
    .i_out_format (o_fmt.detected_format)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import nscp_pkg::*;

    // Counter width of the block under test; the model below saturates at the same width.
    localparam int CNT_W = 16;
    // Cycles without any accepted word before the run is declared hung.
    localparam int WATCHDOG_CYCLES = 4000;
    // Length of the long receiver hold-off used to back the block up.
    localparam int HOLD_OFF_CYCLES = 400;
    // Quiet cycles after the last format word.
    localparam int DRAIN_CYCLES = 8;
    // Bytes to push through the randomised part.
    localparam int RANDOM_ITEMS = 1300;
    // Type-0 units in the closing soak buffer.
    localparam int SOAK_UNITS = 40;
    // Stream shape selector: one codec, or a free mix of all three per unit.
    localparam int MIXED = 3;

    typedef enum logic [1:0] {HUNT, WANT_H0, WANT_H1} hdr_phase_e;
    typedef enum int {K_VPS, K_SPS, K_PPS, K_ZERO, K_SLICE, K_WILD} unit_kind_e;

    // Scoreboard: tracks the probe state word by word and holds the formats still owed.
    class format_scoreboard;
        logic [1:0]       zero_run;
        hdr_phase_e       phase;
        logic [7:0]       h0_held;
        logic [CNT_W-1:0] units      [NUM_CODECS];
        logic [CNT_W-1:0] zero_units [NUM_CODECS];
        logic             rejected   [NUM_CODECS];
        logic             got_sps    [NUM_CODECS];
        logic             got_pps    [NUM_CODECS];
        logic             got_vps    [2];
        logic [1:0]       expected_formats [$];
        int unsigned      mismatches;

        function new();
            mismatches = 0;
            clear_probe();
        endfunction

        function void clear_probe();
            zero_run = 2'd0;
            phase    = HUNT;
            h0_held  = 8'h00;
            for (int c = 0; c < NUM_CODECS; c++) begin
                units[c]      = '0;
                zero_units[c] = '0;
                rejected[c]   = 1'b0;
                got_sps[c]    = 1'b0;
                got_pps[c]    = 1'b0;
            end
            got_vps[0] = 1'b0;
            got_vps[1] = 1'b0;
        endfunction

        function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
            return (&v) ? v : v + 1'b1;
        endfunction

        function void take_unit(int c, logic [5:0] t);
            units[c] = bump(units[c]);
            if (t == PPS_TYPE[c]) begin
                // a PPS only counts once an SPS of the same codec has gone by
                if (got_sps[c]) got_pps[c] = 1'b1;
            end else if (t == SPS_TYPE[c]) begin
                got_sps[c] = 1'b1;
            end else if (HAS_VPS[c] && t == VPS_TYPE[c]) begin
                got_vps[VPS_SLOT[c]] = 1'b1;
            end else if (t == ZERO_TYPE) begin
                zero_units[c] = bump(zero_units[c]);
            end
        endfunction

        function void judge_header(logic [7:0] h0, logic [7:0] h1);
            logic [5:0] hevc_t;
            logic [5:0] avc_t;
            logic [5:0] vvc_t;
            hevc_t = h0[6:1];
            avc_t  = {1'b0, h0[4:0]};
            vvc_t  = {1'b0, h1[7:3]};
            if (h0[7]) begin
                // forbidden bit: no codec allows it
                for (int c = 0; c < NUM_CODECS; c++) rejected[c] = 1'b1;
                return;
            end
            if (hevc_t <= HEVC_MAX_TYPE) take_unit(CODEC_HEVC, hevc_t);
            else rejected[CODEC_HEVC] = 1'b1;
            if (avc_t != ZERO_TYPE && avc_t <= AVC_MAX_TYPE) take_unit(CODEC_AVC, avc_t);
            else rejected[CODEC_AVC] = 1'b1;
            if (h0[6]) rejected[CODEC_VVC] = 1'b1;
            else take_unit(CODEC_VVC, vvc_t);
        endfunction

        function logic [1:0] pick_format();
            logic [CNT_W-1:0] n [NUM_CODECS];
            for (int c = 0; c < NUM_CODECS; c++) n[c] = rejected[c] ? '0 : units[c];
            if (!got_sps[CODEC_AVC] || !got_pps[CODEC_AVC]) n[CODEC_AVC] = '0;
            if (!got_sps[CODEC_HEVC] || !got_pps[CODEC_HEVC] || !got_vps[0])
                n[CODEC_HEVC] = '0;
            if (!got_sps[CODEC_VVC] || !got_pps[CODEC_VVC] || !got_vps[1])
                n[CODEC_VVC] = '0;
            if (rejected[CODEC_AVC] && rejected[CODEC_HEVC] && rejected[CODEC_VVC])
                return FMT_NONE;
            // a stream made only of type-0 units proves nothing
            for (int c = 0; c < NUM_CODECS; c++) if (n[c] == zero_units[c]) n[c] = '0;
            if (n[CODEC_HEVC] == 0 && n[CODEC_AVC] == 0 && n[CODEC_VVC] == 0)
                return FMT_NONE;
            if (n[CODEC_HEVC] == 0) return (n[CODEC_VVC] > n[CODEC_AVC]) ? FMT_VVC : FMT_AVC;
            if (n[CODEC_AVC] == 0) return (n[CODEC_VVC] > n[CODEC_HEVC]) ? FMT_VVC : FMT_HEVC;
            if (n[CODEC_VVC] == 0) return (n[CODEC_AVC] > n[CODEC_HEVC]) ? FMT_AVC : FMT_HEVC;
            if (n[CODEC_HEVC] > n[CODEC_AVC] && n[CODEC_HEVC] > n[CODEC_VVC]) return FMT_HEVC;
            if (n[CODEC_VVC] > n[CODEC_AVC] && n[CODEC_VVC] > n[CODEC_HEVC]) return FMT_VVC;
            return FMT_AVC;
        endfunction

        // Advance the probe by one accepted byte word.
        function void note_byte(logic [7:0] b, logic last);
            case (phase)
                WANT_H0: begin
                    h0_held = b;
                    phase   = WANT_H1;
                end
                WANT_H1: begin
                    judge_header(h0_held, b);
                    phase = HUNT;
                end
                default: begin
                    if (zero_run == 2'd2 && b == 8'h01) phase = WANT_H0;
                end
            endcase
            if (b == 8'h00) zero_run = (zero_run == 2'd2) ? 2'd2 : zero_run + 2'd1;
            else zero_run = 2'd0;
            if (last) begin
                expected_formats.push_back(pick_format());
                clear_probe();
            end
        endfunction

        function void check_format(logic [1:0] got);
            logic [1:0] want;
            if (expected_formats.size() == 0) begin
                mismatches++;
                $display("%0t: detected_format expected nothing, got %0d", $time, got);
                return;
            end
            want = expected_formats.pop_front();
            if (got !== want) begin
                mismatches++;
                $display("%0t: detected_format expected %0d, got %0d", $time, want, got);
            end
        endfunction

        function int pending();
            return expected_formats.size();
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    nscp_byte_if byte_if ();
    nscp_fmt_if  fmt_if ();

    nal_stream_codec_probe_unit #(
        .COUNT_WIDTH(CNT_W)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_byte (byte_if),
        .o_fmt  (fmt_if)
    );

    format_scoreboard sb = new();

    logic [7:0]  buf_bytes [$];     // bytes of the buffer being assembled
    int unsigned sent_bytes    = 0;
    int unsigned idle_cycles   = 0;
    bit          hold_off_req  = 1'b0;

    always #5 i_clk = ~i_clk;

    // Watch both channels at every rising edge: feed the scoreboard and run the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // check before noting, so a format can never be matched to the byte of the same edge
            if (fmt_if.valid && fmt_if.ready) sb.check_format(fmt_if.detected_format);
            if (byte_if.valid && byte_if.ready)
                sb.note_byte(byte_if.data_byte, byte_if.last_byte);
            if ((fmt_if.valid && fmt_if.ready) || (byte_if.valid && byte_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("[nal_stream_codec_probe_unit] ERROR");
                $finish;
            end
        end
    end

    // Format receiver: stall a random number of cycles per word, with calm stretches, and
    // hold off for a long stretch whenever the stimulus asks for back-pressure.
    initial begin : format_sink
        int unsigned stall;
        int unsigned calm;
        calm = 0;
        fmt_if.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                fmt_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            if (calm > 0) begin
                calm--;
                stall = 0;
            end else begin
                stall = $urandom_range(0, 7);
                if ($urandom_range(0, 7) == 0) calm = $urandom_range(4, 16);
            end
            repeat (stall) begin
                fmt_if.ready <= 1'b0;
                @(posedge i_clk);
            end
            fmt_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!fmt_if.valid) @(posedge i_clk);
        end
    end

    // Send the assembled buffer, marking its final byte last; steady drops the idle gaps.
    task automatic send_buffer(input bit steady);
        int unsigned gap;
        int unsigned n;
        n = buf_bytes.size();
        for (int unsigned i = 0; i < n; i++) begin
            gap = steady ? 0 : $urandom_range(0, 7);
            repeat (gap) begin
                byte_if.valid <= 1'b0;
                @(posedge i_clk);
            end
            byte_if.valid     <= 1'b1;
            byte_if.data_byte <= buf_bytes[i];
            byte_if.last_byte <= (i == n - 1);
            @(posedge i_clk);
            while (!byte_if.ready) @(posedge i_clk);
        end
        sent_bytes += n;
        buf_bytes.delete();
    endtask

    // Draw a two-byte header of one codec for the asked unit kind; a wild header is two random bytes.
    function automatic logic [15:0] pick_header(int codec, unit_kind_e kind);
        logic [5:0] t;
        logic [7:0] r0;
        logic [7:0] r1;
        r0 = 8'($urandom);
        r1 = 8'($urandom);
        if (kind == K_WILD) return {r0, r1};
        case (kind)
            K_VPS:   t = VPS_TYPE[codec];
            K_SPS:   t = SPS_TYPE[codec];
            K_PPS:   t = PPS_TYPE[codec];
            K_ZERO:  t = ZERO_TYPE;
            default: begin
                if (codec == CODEC_AVC)       t = 6'($urandom_range(1, 24));
                else if (codec == CODEC_HEVC) t = 6'($urandom_range(0, 40));
                else                          t = 6'($urandom_range(0, 31));
            end
        endcase
        case (codec)
            CODEC_AVC:  return {1'b0, r0[6:5], t[4:0], r1};
            CODEC_HEVC: return {1'b0, t, r0[0], r1};
            default:    return {2'b00, r0[5:0], t[4:0], r1[2:0]};
        endcase
    endfunction

    // Append one unit: three- or four-byte start code, header, short random payload.
    function automatic void add_unit(logic [15:0] hdr);
        if ($urandom_range(0, 3) == 0) buf_bytes.push_back(8'h00);
        buf_bytes.push_back(8'h00);
        buf_bytes.push_back(8'h00);
        buf_bytes.push_back(8'h01);
        buf_bytes.push_back(hdr[15:8]);
        buf_bytes.push_back(hdr[7:0]);
        repeat ($urandom_range(0, 4)) buf_bytes.push_back(8'($urandom));
    endfunction

    // Assemble one random buffer: mostly well-formed parameter sets and slices, some noise.
    task automatic build_random_buffer();
        int         codec;
        int         c;
        int         pick;
        unit_kind_e plan [$];
        case ($urandom_range(0, 7))
            0: begin
                // raw noise, biased towards zeros and ones so start codes turn up
                repeat ($urandom_range(1, 24)) begin
                    pick = $urandom_range(0, 5);
                    if (pick < 3)       buf_bytes.push_back(8'h00);
                    else if (pick == 3) buf_bytes.push_back(8'h01);
                    else                buf_bytes.push_back(8'($urandom));
                end
            end
            1: begin
                repeat ($urandom_range(1, 6))
                    add_unit(pick_header($urandom_range(0, 2),
                                         unit_kind_e'($urandom_range(0, 5))));
            end
            default: begin
                codec = $urandom_range(0, 3);
                if ($urandom_range(0, 7) != 0) plan.push_back(K_VPS);
                if ($urandom_range(0, 5) == 0) begin
                    // PPS ahead of its SPS does not count
                    plan.push_back(K_PPS);
                    plan.push_back(K_SPS);
                end else begin
                    if ($urandom_range(0, 7) != 0) plan.push_back(K_SPS);
                    if ($urandom_range(0, 7) != 0) plan.push_back(K_PPS);
                end
                repeat ($urandom_range(0, 6))
                    plan.push_back(($urandom_range(0, 3) == 0) ? K_ZERO : K_SLICE);
                foreach (plan[i]) begin
                    c = (codec == MIXED) ? $urandom_range(0, 2) : codec;
                    if (c == CODEC_AVC && plan[i] == K_VPS) continue;
                    // type 0 rejects AVC outright; keep it rare there
                    if (c == CODEC_AVC && plan[i] == K_ZERO && $urandom_range(0, 7) != 0)
                        add_unit(pick_header(c, K_SLICE));
                    else
                        add_unit(pick_header(c, plan[i]));
                end
            end
        endcase
        // sometimes end on a start code that never gets its two header bytes
        case ($urandom_range(0, 7))
            0: begin
                buf_bytes.push_back(8'h00);
                buf_bytes.push_back(8'h00);
                buf_bytes.push_back(8'h01);
            end
            1: begin
                buf_bytes.push_back(8'h00);
                buf_bytes.push_back(8'h00);
                buf_bytes.push_back(8'h01);
                buf_bytes.push_back(8'($urandom));
            end
            default: ;
        endcase
        if (buf_bytes.size() == 0) buf_bytes.push_back(8'($urandom));
    endtask

    initial begin : stimulus
        int unsigned random_start;
        byte_if.valid     <= 1'b0;
        byte_if.data_byte <= 8'h00;
        byte_if.last_byte <= 1'b0;
        i_rst_n           <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a byte with no start code, a plain AVC stream whose last byte closes a unit
        // (four-byte start code first), a forbidden header, a truncated header.
        buf_bytes = '{8'hFF};
        send_buffer(1'b0);
        buf_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h42,
                      8'h00, 8'h00, 8'h01, 8'h68, 8'hCE,
                      8'h00, 8'h00, 8'h01, 8'h65, 8'h88};
        send_buffer(1'b0);
        buf_bytes = '{8'h00, 8'h00, 8'h01, 8'h80, 8'h00};
        send_buffer(1'b0);
        buf_bytes = '{8'h00, 8'h00, 8'h01, 8'h67};
        send_buffer(1'b0);

        // Random buffers; about one in five is sent without gaps.
        random_start = sent_bytes;
        while (sent_bytes - random_start < RANDOM_ITEMS) begin
            build_random_buffer();
            send_buffer($urandom_range(0, 4) == 0);
        end

        // Back-pressure: hold the receiver off while short buffers keep coming, so the
        // block parks a last byte and stalls its input.
        hold_off_req = 1'b1;
        repeat (40) begin
            add_unit(pick_header($urandom_range(0, 2), K_SLICE));
            send_buffer(1'b1);
        end

        // Overlap soak: a complete HEVC parameter set, then overlapping start codes
        // with all-zero headers, so each header's trailing zeros open the next code.
        buf_bytes = '{8'h00, 8'h00, 8'h01, 8'h40, 8'h01,
                      8'h00, 8'h00, 8'h01, 8'h42, 8'h01,
                      8'h00, 8'h00, 8'h01, 8'h44, 8'h01,
                      8'h00, 8'h00};
        repeat (SOAK_UNITS) begin
            buf_bytes.push_back(8'h01);
            buf_bytes.push_back(8'h00);
            buf_bytes.push_back(8'h00);
        end
        buf_bytes.push_back(8'hAA);
        send_buffer(1'b1);

        // Drain: drop valid, wait for every owed format, then give the block a few quiet cycles.
        byte_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("[nal_stream_codec_probe_unit] OK");
        end else begin
            $display("[nal_stream_codec_probe_unit] ERROR");
        end
        $finish;
    end
endmodule
